[design/bfiq_pkg.sv]
// ----------------------------------------------------------------------------
// bfiq_pkg: shared types and constants for the Bloom filter core
// Field widths, operation codes and configuration register indexes.
// ----------------------------------------------------------------------------
package bfiq_pkg;

	localparam int KEY_W       = 32;
	localparam int COUNT_W     = 32;
	localparam int CFG_DATA_W  = 32;
	localparam int CFG_IDX_W   = 3;
	localparam int ROW_WIDTH_W = 11;
	localparam int CFG_ROWS    = 3;
	localparam int STEP_W      = 5;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_QUERY  = 1'b1;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t REG_ROW_WIDTH = 3'd0;
	localparam cfg_idx_t REG_ROW0_MULT = 3'd1;
	localparam cfg_idx_t REG_ROW0_ADD  = 3'd2;
	localparam cfg_idx_t REG_ROW1_MULT = 3'd3;
	localparam cfg_idx_t REG_ROW1_ADD  = 3'd4;
	localparam cfg_idx_t REG_ROW2_MULT = 3'd5;
	localparam cfg_idx_t REG_ROW2_ADD  = 3'd6;

	typedef logic [KEY_W-1:0] word_t;

endpackage

[design/bloom_filter_insert_query_core.sv]
// ----------------------------------------------------------------------------
// bloom_filter_insert_query_core: partitioned Bloom filter, insert and query
// Each row hashes the key as (mult * key + add) mod 2^32 and reduces it modulo
// the row width; inserts set one bit per row, queries AND the row bits.
// ----------------------------------------------------------------------------
//
//  Channel  Handshake             Payload
//  -------  --------------------  --------------------------------------
//  in       in_valid / in_stall   operation, key
//  out      out_valid / out_stall maybe_present, insert_count
//  cfg      cfg_valid / cfg_ready cfg_index, cfg_data
//
// A result is formed in order by the bit-serial multiply, the addend step, the
// bit-serial remainder, a memory access and a final step; the core takes no new
// item until it is back in idle.
// After reset a clearing pass over every address zeroes the bit store
// while in_stall stays high. Configuration writes are taken at any time.
// A result waiting under out_stall holds the core in its final state.
module bloom_filter_insert_query_core #(
	parameter int ROWS          = 3,
	parameter int MAX_ROW_WIDTH = 1024
) (
	input  logic                               clk,
	input  logic                               arst_n,

	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               operation,
	input  logic signed [bfiq_pkg::KEY_W-1:0]  key,

	output logic                               out_valid,
	input  logic                               out_stall,
	output logic                               maybe_present,
	output logic [bfiq_pkg::COUNT_W-1:0]       insert_count,

	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bfiq_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfiq_pkg::CFG_DATA_W-1:0]    cfg_data
);

	import bfiq_pkg::*;

	localparam int AW = (MAX_ROW_WIDTH > 1) ? $clog2(MAX_ROW_WIDTH) : 1;
	localparam int WW = $clog2(MAX_ROW_WIDTH + 1);
	localparam int CW = (WW > ROW_WIDTH_W) ? WW : ROW_WIDTH_W;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_MUL,
		S_ADD,
		S_MOD,
		S_MEM,
		S_FIN
	} state_t;

	state_t                 state_q;
	logic [STEP_W-1:0]      step_q;
	logic [AW-1:0]          clr_q;
	word_t                  key_q;
	logic                   op_q;
	logic [COUNT_W-1:0]     cnt_q;
	logic                   out_valid_q;
	logic                   present_q;
	logic [COUNT_W-1:0]     count_out_q;

	logic [ROW_WIDTH_W-1:0] row_width_q;
	word_t                  mult_q [CFG_ROWS];
	word_t                  add_q  [CFG_ROWS];

	logic [CW-1:0]          rw_ext;
	logic [WW-1:0]          eff_w;
	logic                   clearing;
	logic                   mem_we;
	logic [ROWS-1:0]        rd_bits;
	logic                   in_acc;
	logic                   out_free;

	assign cfg_ready     = 1'b1;
	assign in_stall      = (state_q != S_IDLE);
	assign in_acc        = in_valid && !in_stall;
	assign out_valid     = out_valid_q;
	assign maybe_present = present_q;
	assign insert_count  = count_out_q;
	assign out_free      = !out_valid_q || !out_stall;

	assign clearing = (state_q == S_CLEAR);
	assign mem_we   = clearing || ((state_q == S_MEM) && (op_q == OP_INSERT));

	// A zero width behaves as one; widths past the store size saturate.
	always_comb begin
		rw_ext = CW'(row_width_q);
		if (rw_ext == '0) begin
			eff_w = WW'(1);
		end else if (rw_ext > CW'(MAX_ROW_WIDTH)) begin
			eff_w = WW'(MAX_ROW_WIDTH);
		end else begin
			eff_w = WW'(rw_ext);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= ROW_WIDTH_W'(1024);
			mult_q[0]   <= 32'd1;
			add_q[0]    <= 32'd0;
			mult_q[1]   <= 32'd3;
			add_q[1]    <= 32'd1;
			mult_q[2]   <= 32'd5;
			add_q[2]    <= 32'd2;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_ROW_WIDTH: row_width_q <= cfg_data[ROW_WIDTH_W-1:0];
				REG_ROW0_MULT: mult_q[0]   <= cfg_data;
				REG_ROW0_ADD:  add_q[0]    <= cfg_data;
				REG_ROW1_MULT: mult_q[1]   <= cfg_data;
				REG_ROW1_ADD:  add_q[1]    <= cfg_data;
				REG_ROW2_MULT: mult_q[2]   <= cfg_data;
				REG_ROW2_ADD:  add_q[2]    <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			step_q      <= '0;
			clr_q       <= '0;
			key_q       <= '0;
			op_q        <= OP_INSERT;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
			present_q   <= 1'b0;
			count_out_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != S_FIN)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + AW'(1);
					if (clr_q == AW'(MAX_ROW_WIDTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_acc) begin
						key_q   <= word_t'(key);
						op_q    <= operation;
						step_q  <= '0;
						state_q <= S_MUL;
					end
				end
				S_MUL: begin
					key_q  <= {key_q[KEY_W-2:0], 1'b0};
					step_q <= step_q + STEP_W'(1);
					if (step_q == '1) begin
						state_q <= S_ADD;
					end
				end
				S_ADD: begin
					step_q  <= '0;
					state_q <= S_MOD;
				end
				S_MOD: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == '1) begin
						state_q <= S_MEM;
					end
				end
				S_MEM: begin
					if (op_q == OP_INSERT) begin
						cnt_q <= cnt_q + COUNT_W'(1);
					end
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						present_q   <= (op_q == OP_QUERY) && (&rd_bits);
						count_out_q <= cnt_q;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	for (genvar r = 0; r < ROWS; r++) begin : g_row
		localparam int C = (r < CFG_ROWS) ? r : CFG_ROWS - 1;

		word_t          acc_q;
		logic [WW-1:0]  rem_q;
		logic [WW:0]    trial;
		logic [AW-1:0]  addr;
		logic           rd_q;
		logic           mem_q [MAX_ROW_WIDTH];

		// Restoring remainder step: the remainder stays below the width, so
		// the shifted trial is below twice the width and one subtract fits.
		assign trial      = {rem_q, acc_q[KEY_W-1]};
		assign addr       = clearing ? clr_q : rem_q[AW-1:0];
		assign rd_bits[r] = rd_q;

		always_ff @(posedge clk) begin
			unique case (state_q)
				S_IDLE: acc_q <= '0;
				S_MUL: begin
					acc_q <= {acc_q[KEY_W-2:0], 1'b0} + (key_q[KEY_W-1] ? mult_q[C] : '0);
				end
				S_ADD: begin
					acc_q <= acc_q + add_q[C];
					rem_q <= '0;
				end
				S_MOD: begin
					acc_q <= {acc_q[KEY_W-2:0], 1'b0};
					if (trial >= {1'b0, eff_w}) begin
						rem_q <= WW'(trial - {1'b0, eff_w});
					end else begin
						rem_q <= trial[WW-1:0];
					end
				end
				default: ;
			endcase
		end

		always_ff @(posedge clk) begin
			if (mem_we) begin
				mem_q[addr] <= !clearing;
			end
			rd_q <= mem_q[addr];
		end
	end

endmodule
